### hw/rtl/ffpa_pkg.sv
package ffpa_pkg;

   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;
   localparam int BYTES_W = 15;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [BYTES_W-1:0] request_bytes;
      logic [BYTES_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTES_W-1:0]  data_address;
      logic [BYTES_W-1:0]  max_free_bytes;
   } rsp_type;

endpackage

### hw/rtl/ffpa_ram.sv
module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hw/rtl/first_fit_pool_allocator_core.sv
// First-fit pool allocator. The pool is POOL_UNITS units of UNIT_BYTES bytes; each block is a
// header unit followed by its data units, and all block headers live in one header memory with
// one read and one write port. Allocate and query walk the headers from unit 0 in address order
// at one header per cycle; allocate first rounds the request up to whole units. Free finds the
// left neighbour of the freed block by the same walk over the blocks to its left. A request is
// taken only while no other is in progress; a finished response waits in an output register,
// and the next request may be taken meanwhile. After reset the header memory is cleared entry
// by entry, during which no request is taken.
module first_fit_pool_allocator_core
   import ffpa_pkg::*;
#(
   parameter int POOL_UNITS = 1024,
   parameter int UNIT_BYTES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int UNIT_W = $clog2(POOL_UNITS);
   localparam int CNT_W = UNIT_W + 1;
   localparam int DIV_IN_W = BYTES_W + 1;
   localparam int DIV_SHIFT = DIV_IN_W + $clog2(UNIT_BYTES);
   localparam int DIV_M_W = DIV_IN_W + 1;
   localparam int PROD_W = DIV_IN_W + DIV_M_W;
   localparam logic [DIV_M_W-1:0] DIV_MUL = DIV_M_W'((64'd1 << DIV_SHIFT) / UNIT_BYTES);

   typedef struct packed {
      logic              valid;
      logic              free;
      logic [UNIT_W-1:0] size;
   } hdr_type;

   localparam int ENTRY_W = $bits(hdr_type);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_MUL,
      S_DIV_FIX,
      S_DISPATCH,
      S_WALK,
      S_ALLOC_HDR,
      S_QUERY_FIN,
      S_FREE_HDR,
      S_FREE_NEXT,
      S_FREE_WRITE,
      S_FREE_CLR,
      S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [UNIT_W-1:0]   clr_ff, clr_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [DIV_IN_W-1:0] div_a_ff, div_a_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DIV_IN_W-1:0] q_ff, q_in;
   logic                rem_nz_ff, rem_nz_in;
   logic [CNT_W-1:0]    u_ff, u_in;
   logic [UNIT_W-1:0]   h_ff, h_in;
   logic [UNIT_W-1:0]   sz_ff, sz_in;
   logic [UNIT_W-1:0]   best_ff, best_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                ram_we;
   logic [UNIT_W-1:0]   ram_waddr;
   hdr_type             ram_wdata;
   logic [UNIT_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;

   hdr_type             cur;
   logic [CNT_W-1:0]    nxt;
   logic [DIV_IN_W-1:0] div_q0;
   logic [DIV_IN_W-1:0] div_rem0;

   ffpa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(POOL_UNITS)
   ) u_hdr_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign cur = hdr_type'(ram_rdata);
   assign nxt = u_ff + CNT_W'(1) + CNT_W'(cur.size);
   assign div_q0 = DIV_IN_W'(prod_ff >> DIV_SHIFT);
   assign div_rem0 = div_a_ff - DIV_IN_W'(32'(div_q0) * UNIT_BYTES);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      func_in = func_ff;
      div_a_in = div_a_ff;
      prod_in = prod_ff;
      q_in = q_ff;
      rem_nz_in = rem_nz_ff;
      u_in = u_ff;
      h_in = h_ff;
      sz_in = sz_ff;
      best_in = best_ff;
      res_in = res_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ram_we = 1'b0;
      ram_waddr = UNIT_W'(u_ff);
      ram_wdata = '0;
      ram_raddr = UNIT_W'(u_ff);

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == '0) begin
               ram_wdata = '{valid: 1'b1, free: 1'b1, size: UNIT_W'(POOL_UNITS - 1)};
            end
            clr_in = clr_ff + UNIT_W'(1);
            if (clr_ff == UNIT_W'(POOL_UNITS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_data.func;
               res_in = '{status: STATUS_OK, data_address: '0, max_free_bytes: '0};
               u_in = '0;
               best_in = '0;
               ram_raddr = '0;
               unique case (req_data.func)
                  FUNC_ALLOC: begin
                     div_a_in = DIV_IN_W'(req_data.request_bytes) + DIV_IN_W'(UNIT_BYTES - 1);
                     state_in = S_DIV_MUL;
                  end
                  FUNC_FREE: begin
                     div_a_in = DIV_IN_W'(req_data.address);
                     state_in = S_DIV_MUL;
                  end
                  FUNC_QUERY: begin
                     state_in = S_WALK;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_DIV_MUL: begin
            prod_in = PROD_W'(div_a_ff) * PROD_W'(DIV_MUL);
            state_in = S_DIV_FIX;
         end
         S_DIV_FIX: begin
            if (32'(div_rem0) >= UNIT_BYTES) begin
               q_in = div_q0 + DIV_IN_W'(1);
               rem_nz_in = (32'(div_rem0) != UNIT_BYTES);
            end else begin
               q_in = div_q0;
               rem_nz_in = (div_rem0 != '0);
            end
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (func_ff == FUNC_ALLOC) begin
               if (q_ff == '0) begin
                  res_in.status = STATUS_NO_FIT;
                  state_in = S_RESP;
               end else begin
                  u_in = '0;
                  ram_raddr = '0;
                  state_in = S_WALK;
               end
            end else begin
               if (rem_nz_ff || q_ff == '0 || 32'(q_ff) > POOL_UNITS) begin
                  res_in.status = STATUS_BAD_ADDR;
                  state_in = S_RESP;
               end else begin
                  h_in = UNIT_W'(q_ff - DIV_IN_W'(1));
                  ram_raddr = UNIT_W'(q_ff - DIV_IN_W'(1));
                  state_in = S_FREE_HDR;
               end
            end
         end
         S_WALK: begin
            ram_raddr = UNIT_W'(nxt);
            u_in = nxt;
            case (func_ff)
               FUNC_ALLOC: begin
                  if (cur.free && 32'(cur.size) >= 32'(q_ff)) begin
                     u_in = u_ff;
                     if (32'(cur.size) > 32'(q_ff)) begin
                        ram_we = 1'b1;
                        ram_waddr = UNIT_W'(32'(u_ff) + 1 + 32'(q_ff));
                        ram_wdata = '{valid: 1'b1, free: 1'b1,
                                      size: UNIT_W'(32'(cur.size) - 32'(q_ff) - 1)};
                     end
                     state_in = S_ALLOC_HDR;
                  end else if (32'(nxt) >= POOL_UNITS) begin
                     res_in.status = STATUS_NO_FIT;
                     state_in = S_RESP;
                  end
               end
               FUNC_FREE: begin
                  if (nxt >= CNT_W'(h_ff)) begin
                     u_in = u_ff;
                     if (nxt == CNT_W'(h_ff) && cur.free) begin
                        ram_we = 1'b1;
                        ram_waddr = UNIT_W'(u_ff);
                        ram_wdata = '{valid: 1'b1, free: 1'b1,
                                      size: cur.size + sz_ff + UNIT_W'(1)};
                        state_in = S_FREE_CLR;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
               end
               default: begin
                  if (cur.free && cur.size > best_ff) begin
                     best_in = cur.size;
                  end
                  if (32'(nxt) >= POOL_UNITS) begin
                     state_in = S_QUERY_FIN;
                  end
               end
            endcase
         end
         S_ALLOC_HDR: begin
            ram_we = 1'b1;
            ram_waddr = UNIT_W'(u_ff);
            ram_wdata = '{valid: 1'b1, free: 1'b0, size: UNIT_W'(q_ff)};
            res_in.data_address = BYTES_W'((32'(u_ff) + 1) * UNIT_BYTES);
            state_in = S_RESP;
         end
         S_QUERY_FIN: begin
            res_in.max_free_bytes = BYTES_W'(32'(best_ff) * UNIT_BYTES);
            state_in = S_RESP;
         end
         S_FREE_HDR: begin
            if (!cur.valid || cur.free) begin
               res_in.status = STATUS_BAD_ADDR;
               state_in = S_RESP;
            end else begin
               sz_in = cur.size;
               u_in = CNT_W'(h_ff) + CNT_W'(1) + CNT_W'(cur.size);
               ram_raddr = UNIT_W'(CNT_W'(h_ff) + CNT_W'(1) + CNT_W'(cur.size));
               if (32'(CNT_W'(h_ff) + CNT_W'(1) + CNT_W'(cur.size)) < POOL_UNITS) begin
                  state_in = S_FREE_NEXT;
               end else begin
                  state_in = S_FREE_WRITE;
               end
            end
         end
         S_FREE_NEXT: begin
            if (cur.valid && cur.free) begin
               sz_in = sz_ff + cur.size + UNIT_W'(1);
               ram_we = 1'b1;
               ram_waddr = UNIT_W'(u_ff);
               ram_wdata = '0;
            end
            state_in = S_FREE_WRITE;
         end
         S_FREE_WRITE: begin
            ram_we = 1'b1;
            ram_waddr = h_ff;
            ram_wdata = '{valid: 1'b1, free: 1'b1, size: sz_ff};
            u_in = '0;
            ram_raddr = '0;
            if (h_ff == '0) begin
               state_in = S_RESP;
            end else begin
               state_in = S_WALK;
            end
         end
         S_FREE_CLR: begin
            ram_we = 1'b1;
            ram_waddr = h_ff;
            ram_wdata = '0;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff <= func_in;
      div_a_ff <= div_a_in;
      prod_ff <= prod_in;
      q_ff <= q_in;
      rem_nz_ff <= rem_nz_in;
      u_ff <= u_in;
      h_ff <= h_in;
      sz_ff <= sz_in;
      best_ff <= best_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### dv/tb_first_fit_pool_allocator_core.sv
`timescale 1ns / 1ps

module tb_first_fit_pool_allocator_core;
   import ffpa_pkg::*;

   localparam int POOL_UNITS = 1024;
   localparam int UNIT_BYTES = 32;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 2500;
   localparam int HOLD_CYCLES = 3000;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic        present;
      logic        is_free;
      logic [16:0] units;
   } pool_hdr_type;

   typedef struct {
      req_type req;
      bit      exact;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pool_hdr_type unit_hdr [POOL_UNITS];
   rsp_type      awaited_rsp [$];
   int           live_addr [$];
   dir_row_type  dir_rows [$];
   rsp_type      want_rsp;

   int  last_freed_addr = 0;
   int  error_count = 0;
   int  cycle_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  alloc_ok_count = 0;
   int  free_ok_count = 0;
   int  reject_count = 0;
   int  query_count = 0;
   int  sender_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_left = 0;
   bit  hold_start = 1'b0;

   first_fit_pool_allocator_core #(
      .POOL_UNITS(POOL_UNITS),
      .UNIT_BYTES(UNIT_BYTES)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= 40) begin
         $display("%0t ERROR %s: got %0d expected %0d", $time, what, got, want);
      end
   endtask

   function automatic rsp_type compute_pool_reply(req_type r);
      rsp_type o;
      int need, u, sz, h, nx, prev, a, best;
      bit found, have_prev;
      o = '0;
      case (r.func)
         FUNC_ALLOC: begin
            need = (int'(r.request_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
            found = 1'b0;
            u = 0;
            if (need != 0) begin
               while (u < POOL_UNITS && !found) begin
                  sz = int'(unit_hdr[u].units);
                  if (unit_hdr[u].is_free && sz >= need) begin
                     if (sz > need && u + 1 + need < POOL_UNITS) begin
                        unit_hdr[u + 1 + need] = '{1'b1, 1'b1, 17'(sz - need - 1)};
                     end
                     unit_hdr[u] = '{1'b1, 1'b0, 17'(need)};
                     o.data_address = 15'((u + 1) * UNIT_BYTES);
                     found = 1'b1;
                  end else begin
                     u = u + 1 + sz;
                  end
               end
            end
            if (!found) o.status = STATUS_NO_FIT;
         end
         FUNC_FREE: begin
            a = int'(r.address);
            h = a / UNIT_BYTES - 1;
            if (a % UNIT_BYTES != 0 || a == 0 || h >= POOL_UNITS) begin
               o.status = STATUS_BAD_ADDR;
            end else if (!unit_hdr[h].present || unit_hdr[h].is_free) begin
               o.status = STATUS_BAD_ADDR;
            end else begin
               sz = int'(unit_hdr[h].units);
               nx = h + 1 + sz;
               // merge with free right neighbor
               if (nx < POOL_UNITS && unit_hdr[nx].present && unit_hdr[nx].is_free) begin
                  sz = sz + int'(unit_hdr[nx].units) + 1;
                  unit_hdr[nx] = '0;
               end
               unit_hdr[h] = '{1'b1, 1'b1, 17'(sz)};
               // walk to find left neighbor
               u = 0;
               prev = 0;
               have_prev = 1'b0;
               while (u < h) begin
                  prev = u;
                  have_prev = 1'b1;
                  u = u + 1 + int'(unit_hdr[u].units);
               end
               if (have_prev && u == h && unit_hdr[prev].is_free) begin
                  unit_hdr[prev] = '{1'b1, 1'b1, 17'(int'(unit_hdr[prev].units) + sz + 1)};
                  unit_hdr[h] = '0;
               end
            end
         end
         FUNC_QUERY: begin
            u = 0;
            best = 0;
            while (u < POOL_UNITS) begin
               sz = int'(unit_hdr[u].units);
               if (unit_hdr[u].is_free && sz > best) best = sz;
               u = u + 1 + sz;
            end
            o.max_free_bytes = 15'(best * UNIT_BYTES);
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic void add_row(logic [FUNC_W-1:0] f, int nbytes, int addr, bit exact,
                                   logic [STATUS_W-1:0] st, int data, int maxf);
      dir_row_type row;
      row.req.func = f;
      row.req.request_bytes = 15'(nbytes);
      row.req.address = 15'(addr);
      row.exact = exact;
      row.want.status = st;
      row.want.data_address = 15'(data);
      row.want.max_free_bytes = 15'(maxf);
      dir_rows.push_back(row);
   endfunction

   function automatic req_type pick_random_request();
      req_type r;
      int sel, k, alloc_pct;
      r.func = FUNC_ALLOC;
      r.request_bytes = 15'($urandom);
      r.address = 15'($urandom);
      alloc_pct = (live_addr.size() > 40) ? 35 : 48;
      sel = $urandom_range(0, 99);
      if (sel < alloc_pct) begin
         k = $urandom_range(0, 99);
         if (k < 70) r.request_bytes = 15'($urandom_range(1, 160));
         else if (k < 90) r.request_bytes = 15'($urandom_range(161, 2048));
         else if (k < 96) r.request_bytes = 15'($urandom_range(2049, 32767));
      end else if (sel < 86) begin
         r.func = FUNC_FREE;
         k = $urandom_range(0, 9);
         if (live_addr.size() > 0 && k < 8) begin
            r.address = 15'(live_addr[$urandom_range(0, live_addr.size() - 1)]);
         end else if (k == 8) begin
            r.address = 15'($urandom_range(0, POOL_UNITS - 1) * UNIT_BYTES);
         end else if ($urandom_range(0, 1) == 1) begin
            r.address = 15'(last_freed_addr);
         end
      end else if (sel < 97) begin
         r.func = FUNC_QUERY;
      end else begin
         r.func = FUNC_UNUSED;
      end
      return r;
   endfunction

   task automatic offer_request(req_type r, bit exact, rsp_type want);
      rsp_type pred;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pred = compute_pool_reply(r);
      awaited_rsp.push_back(exact ? want : pred);
      sent_count++;
      if (pred.status != STATUS_OK) reject_count++;
      if (r.func == FUNC_QUERY) query_count++;
      if (r.func == FUNC_ALLOC && pred.status == STATUS_OK) begin
         alloc_ok_count++;
         live_addr.push_back(int'(pred.data_address));
      end
      if (r.func == FUNC_FREE && pred.status == STATUS_OK) begin
         free_ok_count++;
         last_freed_addr = int'(r.address);
         foreach (live_addr[i]) begin
            if (live_addr[i] == int'(r.address)) begin
               live_addr.delete(i);
               break;
            end
         end
      end
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic run_random(int n, int send_pct, int stall_pct);
      sender_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) offer_request(pick_random_request(), 1'b0, '0);
   endtask

   // receiver ready, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("first_fit_pool_allocator_core: mismatch");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected transfer, status", int'(rsp_data.status), -1);
         end else begin
            want_rsp = awaited_rsp.pop_front();
            checked_count++;
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", int'(rsp_data.status), int'(want_rsp.status));
            if (rsp_data.data_address !== want_rsp.data_address)
               report_mismatch("data_address", int'(rsp_data.data_address),
                               int'(want_rsp.data_address));
            if (rsp_data.max_free_bytes !== want_rsp.max_free_bytes)
               report_mismatch("max_free_bytes", int'(rsp_data.max_free_bytes),
                               int'(want_rsp.max_free_bytes));
         end
      end
   end

   initial begin
      foreach (unit_hdr[i]) unit_hdr[i] = '0;
      unit_hdr[0] = '{1'b1, 1'b1, 17'(POOL_UNITS - 1)};

      add_row(FUNC_QUERY, 0, 0, 1, STATUS_OK, 0, (POOL_UNITS - 1) * UNIT_BYTES);
      add_row(FUNC_ALLOC, 0, 0, 1, STATUS_NO_FIT, 0, 0);
      add_row(FUNC_ALLOC, 32767, 0, 1, STATUS_NO_FIT, 0, 0);
      add_row(FUNC_ALLOC, 32736, 0, 1, STATUS_OK, 32, 0);
      add_row(FUNC_QUERY, 0, 0, 1, STATUS_OK, 0, 0);
      add_row(FUNC_ALLOC, 1, 0, 1, STATUS_NO_FIT, 0, 0);
      add_row(FUNC_FREE, 0, 32, 1, STATUS_OK, 0, 0);
      add_row(FUNC_FREE, 0, 32, 1, STATUS_BAD_ADDR, 0, 0);
      add_row(FUNC_FREE, 0, 0, 1, STATUS_BAD_ADDR, 0, 0);
      add_row(FUNC_FREE, 0, 33, 1, STATUS_BAD_ADDR, 0, 0);
      add_row(FUNC_FREE, 32767, 32767, 1, STATUS_BAD_ADDR, 0, 0);
      add_row(FUNC_UNUSED, 32767, 32767, 1, STATUS_OK, 0, 0);
      add_row(FUNC_ALLOC, 1, 0, 1, STATUS_OK, 32, 0);
      add_row(FUNC_ALLOC, 32, 0, 1, STATUS_OK, 96, 0);
      add_row(FUNC_ALLOC, 33, 0, 1, STATUS_OK, 160, 0);
      add_row(FUNC_FREE, 0, 96, 1, STATUS_OK, 0, 0);
      add_row(FUNC_ALLOC, 64, 0, 0, STATUS_OK, 0, 0);
      add_row(FUNC_QUERY, 0, 0, 0, STATUS_OK, 0, 0);
      add_row(FUNC_FREE, 0, 32, 0, STATUS_OK, 0, 0);
      add_row(FUNC_FREE, 0, 160, 0, STATUS_OK, 0, 0);
      add_row(FUNC_FREE, 0, 256, 0, STATUS_OK, 0, 0);
      add_row(FUNC_ALLOC, 32704, 0, 0, STATUS_OK, 0, 0);
      add_row(FUNC_QUERY, 0, 0, 0, STATUS_OK, 0, 0);
      add_row(FUNC_FREE, 0, 32, 0, STATUS_OK, 0, 0);
      add_row(FUNC_QUERY, 0, 0, 0, STATUS_OK, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) offer_request(dir_rows[i].req, dir_rows[i].exact, dir_rows[i].want);
      wait_drain();

      run_random(300, 0, 0);
      wait_drain();
      run_random(250, 80, 0);
      wait_drain();
      run_random(250, 0, 80);
      wait_drain();
      run_random(250, 35, 35);
      wait_drain();

      // receiver holds off while requests keep coming
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_start = 1'b1;
      @(negedge clock);
      run_random(120, 0, 0);

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests (%0d directed) and %0d responses checked in %0d cycles",
               sent_count, dir_rows.size(), checked_count, cycle_count);
      $display("%0d allocs ok, %0d frees ok, %0d queries, %0d rejected",
               alloc_ok_count, free_ok_count, query_count, reject_count);
      if (error_count == 0 && awaited_rsp.size() == 0) begin
         $display("first_fit_pool_allocator_core: match");
      end else begin
         $display("first_fit_pool_allocator_core: mismatch");
      end
      $finish;
   end

endmodule
